/* hw/rtl/scpr_pkg.sv */
`default_nettype none
package scpr_pkg;

  localparam int unsigned COMB_COUNT = 4;
  localparam int unsigned LINE_W     = 2;
  localparam int unsigned DELAY_W    = 13;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned WET_W      = 17;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [DELAY_W-1:0] DELAY0_RST   = 13'd1776;
  localparam logic [DELAY_W-1:0] DELAY1_RST   = 13'd1968;
  localparam logic [DELAY_W-1:0] DELAY2_RST   = 13'd2064;
  localparam logic [DELAY_W-1:0] DELAY3_RST   = 13'd2256;
  localparam logic [COEF_W-1:0]  FEEDBACK_RST = 16'd50790;
  localparam logic [COEF_W-1:0]  DAMPING_RST  = 16'd16384;
  localparam logic [DELAY_W-1:0] PREDELAY_RST = 13'd0;
  localparam logic [WET_W-1:0]   WET_RST      = 17'd32768;
  localparam logic [WET_W-1:0]   UNITY_GAIN   = 17'd65536;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DELAY0   = 3'd0,
    REG_DELAY1   = 3'd1,
    REG_DELAY2   = 3'd2,
    REG_DELAY3   = 3'd3,
    REG_FEEDBACK = 3'd4,
    REG_DAMPING  = 3'd5,
    REG_PREDELAY = 3'd6,
    REG_WET      = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRE_RD,
    S_PRE_LAT,
    S_RD,
    S_MUL,
    S_DAMP,
    S_FBMUL,
    S_WR,
    S_MIXMUL,
    S_MIX
  } state_e;

  typedef struct packed {
    logic              load_in;
    logic              pre_rd;
    logic              pre_lat;
    logic              comb_rd;
    logic              mul_damp;
    logic              damp_upd;
    logic              mul_fb;
    logic              comb_wr;
    logic              mul_mix;
    logic              mix_out;
    logic [LINE_W-1:0] line;
  } cmd_t;

  typedef struct packed {
    logic pre_on;
  } stat_t;

endpackage
`default_nettype wire

/* hw/rtl/scpr_ctrl.sv */
`default_nettype none
module scpr_ctrl
  import scpr_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  wire   out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic out_valid_q, out_valid_d;
  logic last_line;
  logic out_free;

  assign last_line = (line_q == LINE_W'(COMB_COUNT - 1));
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    line_d  = line_q;
    case (state_q)
      S_IDLE: begin
        line_d = '0;
        if (in_valid_i) begin
          state_d = stat_i.pre_on ? S_PRE_RD : S_RD;
        end
      end
      S_PRE_RD:  state_d = S_PRE_LAT;
      S_PRE_LAT: state_d = S_RD;
      S_RD:      state_d = S_MUL;
      S_MUL:     state_d = S_DAMP;
      S_DAMP:    state_d = S_FBMUL;
      S_FBMUL:   state_d = S_WR;
      S_WR: begin
        if (last_line) begin
          state_d = S_MIXMUL;
        end else begin
          line_d  = line_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_MIXMUL: state_d = S_MIX;
      S_MIX: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.line  = line_q;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      S_PRE_RD:  cmd_o.pre_rd   = 1'b1;
      S_PRE_LAT: cmd_o.pre_lat  = 1'b1;
      S_RD:      cmd_o.comb_rd  = 1'b1;
      S_MUL:     cmd_o.mul_damp = 1'b1;
      S_DAMP:    cmd_o.damp_upd = 1'b1;
      S_FBMUL:   cmd_o.mul_fb   = 1'b1;
      S_WR:      cmd_o.comb_wr  = 1'b1;
      S_MIXMUL:  cmd_o.mul_mix  = 1'b1;
      S_MIX: begin
        if (out_free) begin
          cmd_o.mix_out = 1'b1;
          out_valid_d   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      line_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      line_q      <= line_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/scpr_datapath.sv */
`default_nettype none
module scpr_datapath
  import scpr_pkg::*;
#(
  parameter int unsigned COMB_DEPTH     = 8192,
  parameter int unsigned PREDELAY_DEPTH = 8192,
  parameter int unsigned SAMPLE_WIDTH   = 24
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [CFG_ADDR_W-1:0]               cfg_addr_i,
  input  wire  [CFG_DATA_W-1:0]               cfg_data_i,
  input  cmd_t                                cmd_i,
  output stat_t                               stat_o,
  input  wire  signed [1:0][SAMPLE_WIDTH-1:0] din_i,
  output logic signed [1:0][SAMPLE_WIDTH-1:0] dout_o
);

  localparam int unsigned SW  = SAMPLE_WIDTH;
  localparam int unsigned PW  = SW + 18;
  localparam int unsigned CAW = (COMB_DEPTH > 1) ? $clog2(COMB_DEPTH) : 1;
  localparam int unsigned PAW = (PREDELAY_DEPTH > 1) ? $clog2(PREDELAY_DEPTH) : 1;
  localparam int unsigned MAW = $clog2(COMB_COUNT * COMB_DEPTH);
  localparam int unsigned XW  = 15;
  localparam logic signed [PW:0] SMAX = (PW+1)'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [PW:0] SMIN = -SMAX - 1;
  localparam logic signed [PW:0] HALF = (PW+1)'(32768);

  function automatic logic signed [SW-1:0] sat(input logic signed [PW:0] v);
    if (v > SMAX) begin
      return SMAX[SW-1:0];
    end else if (v < SMIN) begin
      return SMIN[SW-1:0];
    end
    return v[SW-1:0];
  endfunction

  function automatic logic signed [PW:0] rnd(input logic signed [PW:0] v);
    return (v + HALF) >>> 16;
  endfunction

  logic [COMB_COUNT-1:0][DELAY_W-1:0] delay_q;
  logic [COEF_W-1:0]  fb_q;
  logic [COEF_W-1:0]  damp_coef_q;
  logic [DELAY_W-1:0] pre_len_q;
  logic [WET_W-1:0]   wet_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q[0]  <= DELAY0_RST;
      delay_q[1]  <= DELAY1_RST;
      delay_q[2]  <= DELAY2_RST;
      delay_q[3]  <= DELAY3_RST;
      fb_q        <= FEEDBACK_RST;
      damp_coef_q <= DAMPING_RST;
      pre_len_q   <= PREDELAY_RST;
      wet_q       <= WET_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_DELAY0, REG_DELAY1, REG_DELAY2, REG_DELAY3: begin
          delay_q[cfg_addr_i[LINE_W-1:0]] <= cfg_data_i[DELAY_W-1:0];
        end
        REG_FEEDBACK: fb_q        <= cfg_data_i[COEF_W-1:0];
        REG_DAMPING:  damp_coef_q <= cfg_data_i[COEF_W-1:0];
        REG_PREDELAY: pre_len_q   <= cfg_data_i[DELAY_W-1:0];
        REG_WET:      wet_q       <= cfg_data_i[WET_W-1:0];
        default: ;
      endcase
    end
  end

  assign stat_o.pre_on = (pre_len_q != '0);

  logic [CAW-1:0] comb_wp_q;
  logic           comb_wrap_q;
  logic [PAW-1:0] pre_wp_q;
  logic           pre_wrap_q;
  logic           comb_adv;

  assign comb_adv = cmd_i.comb_wr && (cmd_i.line == LINE_W'(COMB_COUNT - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comb_wp_q   <= '0;
      comb_wrap_q <= 1'b0;
      pre_wp_q    <= '0;
      pre_wrap_q  <= 1'b0;
    end else begin
      if (comb_adv) begin
        if (comb_wp_q == CAW'(COMB_DEPTH - 1)) begin
          comb_wp_q   <= '0;
          comb_wrap_q <= 1'b1;
        end else begin
          comb_wp_q <= comb_wp_q + 1'b1;
        end
      end
      if (cmd_i.pre_rd) begin
        if (pre_wp_q == PAW'(PREDELAY_DEPTH - 1)) begin
          pre_wp_q   <= '0;
          pre_wrap_q <= 1'b1;
        end else begin
          pre_wp_q <= pre_wp_q + 1'b1;
        end
      end
    end
  end

  logic [PAW-1:0] pre_dist;
  logic [PAW-1:0] pre_rp;
  logic           pre_ok;

  always_comb begin
    if (32'(pre_len_q) > 32'(PREDELAY_DEPTH - 1)) begin
      pre_dist = PAW'(PREDELAY_DEPTH - 1);
    end else begin
      pre_dist = PAW'(pre_len_q);
    end
    if (pre_wp_q >= pre_dist) begin
      pre_rp = pre_wp_q - pre_dist;
    end else begin
      pre_rp = PAW'(32'(pre_wp_q) + PREDELAY_DEPTH - 32'(pre_dist));
    end
    pre_ok = pre_wrap_q || (pre_rp < pre_wp_q);
  end

  logic [MAW-1:0] line_base;
  logic [MAW-1:0] wr_addr;
  logic [WET_W-1:0] wet_gain;
  logic [WET_W-1:0] dry_gain;
  logic [WET_W-1:0] damp_inv;

  assign line_base = MAW'(cmd_i.line) * MAW'(COMB_DEPTH);
  assign wr_addr   = line_base + MAW'(comb_wp_q);
  assign wet_gain  = (wet_q > UNITY_GAIN) ? UNITY_GAIN : wet_q;
  assign dry_gain  = UNITY_GAIN - wet_gain;
  assign damp_inv  = UNITY_GAIN - WET_W'(damp_coef_q);

  for (genvar ch = 0; ch < 2; ch++) begin : g_ch
    logic signed [SW-1:0] comb_mem [COMB_COUNT*COMB_DEPTH];
    logic signed [SW-1:0] pre_mem  [PREDELAY_DEPTH];

    logic signed [SW-1:0] dry_q, x_q, crd_q, prd_q, raw_q, dl_q, out_q;
    logic                 cok_q, pok_q;
    logic signed [PW-1:0] pa_q, pc_q;
    logic signed [SW+1:0] sum_q;
    logic signed [COMB_COUNT-1:0][SW-1:0] damp_q;

    logic [XW-1:0]        dext;
    logic [CAW-1:0]       rd_span;
    logic [CAW-1:0]       rp;
    logic                 rd_ok;
    logic [MAW-1:0]       rd_addr;
    logic signed [SW-1:0] raw;
    logic signed [SW-1:0] wet;
    logic signed [SW+1:0] wet_sum;
    logic signed [PW:0]   mix_sum;

    always_comb begin
      if (ch == 1) begin
        dext = XW'(delay_q[cmd_i.line]) + XW'(cmd_i.line) + XW'(1);
      end else begin
        dext = XW'(delay_q[cmd_i.line]);
      end
      if (32'(dext) > 32'(COMB_DEPTH - 1)) begin
        rd_span = CAW'(COMB_DEPTH - 1);
      end else begin
        rd_span = CAW'(dext);
      end
      if (comb_wp_q >= rd_span) begin
        rp = comb_wp_q - rd_span;
      end else begin
        rp = CAW'(32'(comb_wp_q) + COMB_DEPTH - 32'(rd_span));
      end
      rd_ok   = (comb_wrap_q || (rp < comb_wp_q)) && (dext != '0);
      rd_addr = line_base + MAW'(rp);
      raw     = cok_q ? crd_q : '0;
      wet_sum = (sum_q + (SW+2)'(2)) >>> 2;
      wet     = wet_sum[SW-1:0];
      mix_sum = (PW+1)'(pa_q) + (PW+1)'(pc_q);
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.pre_rd) begin
        prd_q              <= pre_mem[pre_rp];
        pre_mem[pre_wp_q]  <= dry_q;
      end
      if (cmd_i.comb_rd) begin
        crd_q <= comb_mem[rd_addr];
      end
      if (cmd_i.comb_wr) begin
        comb_mem[wr_addr] <= sat((PW+1)'(x_q) + rnd((PW+1)'(pa_q)));
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.load_in) begin
        dry_q <= din_i[ch];
        x_q   <= din_i[ch];
        sum_q <= '0;
      end
      if (cmd_i.pre_rd) begin
        pok_q <= pre_ok;
      end
      if (cmd_i.pre_lat) begin
        x_q <= pok_q ? prd_q : '0;
      end
      if (cmd_i.comb_rd) begin
        cok_q <= rd_ok;
      end
      if (cmd_i.mul_damp) begin
        raw_q <= raw;
        pa_q  <= PW'(raw) * PW'($signed({1'b0, damp_inv}));
        pc_q  <= PW'($signed(damp_q[cmd_i.line])) * PW'($signed({1'b0, damp_coef_q}));
      end
      if (cmd_i.damp_upd) begin
        dl_q <= sat(rnd(mix_sum));
      end
      if (cmd_i.mul_fb) begin
        pa_q <= PW'(dl_q) * PW'($signed({1'b0, fb_q}));
      end
      if (cmd_i.comb_wr) begin
        sum_q <= sum_q + (SW+2)'(raw_q);
      end
      if (cmd_i.mul_mix) begin
        pa_q <= PW'(dry_q) * PW'($signed({1'b0, dry_gain}));
        pc_q <= PW'(wet) * PW'($signed({1'b0, wet_gain}));
      end
      if (cmd_i.mix_out) begin
        out_q <= sat(rnd(mix_sum));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        damp_q <= '0;
      end else if (cmd_i.damp_upd) begin
        damp_q[cmd_i.line] <= sat(rnd(mix_sum));
      end
    end

    assign dout_o[ch] = out_q;
  end

endmodule
`default_nettype wire

/* hw/rtl/stereo_comb_plate_reverb.sv */
// Stereo reverb built from four damped feedback comb lines per channel, with an optional
// predelay ring and a dry/wet mix. One stereo request is taken at a time. After acceptance the
// predelay read and latch run if predelay is on, then the shared multiply and damping sequence
// steps through the comb lines one by one (read, multiply, damp, feedback multiply, write), and
// the mix is formed and moved to the output register. The next request can be taken as soon as
// the result sits in the output register; an output stall holds the mix step and so the next
// request. The delay memories need no clearing after reset: entries not yet written since reset
// read as zero.
`default_nettype none
module stereo_comb_plate_reverb
  import scpr_pkg::*;
#(
  parameter int unsigned COMB_DEPTH     = 8192,
  parameter int unsigned PREDELAY_DEPTH = 8192,
  parameter int unsigned SAMPLE_WIDTH   = 24
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    cfg_we_i,
  input  wire  [CFG_ADDR_W-1:0]                  cfg_addr_i,
  input  wire  [CFG_DATA_W-1:0]                  cfg_data_i,
  input  wire                                    s_axis_tvalid,
  output logic                                   s_axis_tready,
  // Fields from bit 0: left_in, right_in, zero padding.
  input  wire  [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire                                    m_axis_tready,
  // Fields from bit 0: left_out, right_out, zero padding.
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    m_axis_tdata
);

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned TW = ((2*SW+7)/8)*8;

  cmd_t  cmd;
  stat_t stat;
  logic signed [1:0][SW-1:0] din;
  logic signed [1:0][SW-1:0] dout;

  assign din[0] = s_axis_tdata[SW-1:0];
  assign din[1] = s_axis_tdata[2*SW-1:SW];

  scpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  scpr_datapath #(
    .COMB_DEPTH     (COMB_DEPTH),
    .PREDELAY_DEPTH (PREDELAY_DEPTH),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .din_i      (din),
    .dout_o     (dout)
  );

  assign m_axis_tdata = TW'({dout[1], dout[0]});

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request accepted while one is in work");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mix_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten before it was taken");

  a_valid_from_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.mix_out))
    else $error("output valid raised without a finished mix");

endmodule
`default_nettype wire

/* test/testbench.sv */
`default_nettype none
module testbench;
  import scpr_pkg::*;

  localparam int unsigned DEPTH = 8192;
  localparam longint SMAX = 64'sd8388607;
  localparam longint SMIN = -64'sd8388608;

  typedef struct packed {
    logic signed [23:0] left;
    logic signed [23:0] right;
  } pair_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [47:0]           m_axis_tdata;

  stereo_comb_plate_reverb uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_addr_i(cfg_addr_i), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mirror of the reverb settings and memories.
  int unsigned delay_set[4];
  int unsigned feedback_set, damping_set, predelay_set, wet_set;
  int          comb_left[4*DEPTH];
  int          comb_right[4*DEPTH];
  int          pre_left[DEPTH];
  int          pre_right[DEPTH];
  longint      damper_l[4];
  longint      damper_r[4];
  int unsigned comb_wp, pre_wp;

  pair_t expected_pairs[$];
  int    errors = 0;
  int    pairs_sent = 0;
  int    pairs_checked = 0;
  bit    idle_on = 1'b1;
  int    hold_left = 0;
  int    stall_left = 0;

  function automatic longint clip(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic longint rnd16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic int unsigned ring_at(int unsigned wp, int unsigned d);
    if (d > DEPTH - 1) d = DEPTH - 1;
    return (wp + DEPTH - d) % DEPTH;
  endfunction

  function automatic longint damp_next(longint x, longint s);
    longint d;
    d = longint'(damping_set);
    return clip(rnd16(x * (65536 - d) + s * d));
  endfunction

  function automatic pair_t reverb_predict(logic signed [23:0] l_in, logic signed [23:0] r_in);
    longint      xl, xr, sl, sr, rl, rr, dl, dr, w;
    int unsigned base, rp;
    pair_t       res;
    xl = l_in;
    xr = r_in;
    sl = 0;
    sr = 0;
    if (predelay_set != 0) begin
      rp = ring_at(pre_wp, predelay_set);
      xl = pre_left[rp];
      xr = pre_right[rp];
      pre_left[pre_wp] = l_in;
      pre_right[pre_wp] = r_in;
      pre_wp = (pre_wp + 1) % DEPTH;
    end
    for (int i = 0; i < 4; i++) begin
      base = i * DEPTH;
      rl = (delay_set[i] != 0) ? comb_left[base + ring_at(comb_wp, delay_set[i])] : 0;
      rr = comb_right[base + ring_at(comb_wp, delay_set[i] + i + 1)];
      dl = damp_next(rl, damper_l[i]);
      dr = damp_next(rr, damper_r[i]);
      damper_l[i] = dl;
      damper_r[i] = dr;
      comb_left[base + comb_wp] = int'(clip(xl + rnd16(dl * longint'(feedback_set))));
      comb_right[base + comb_wp] = int'(clip(xr + rnd16(dr * longint'(feedback_set))));
      sl += rl;
      sr += rr;
    end
    comb_wp = (comb_wp + 1) % DEPTH;
    w = (wet_set > 65536) ? 65536 : longint'(wet_set);
    res.left = 24'(clip(rnd16(longint'(l_in) * (65536 - w) + ((sl + 2) >>> 2) * w)));
    res.right = 24'(clip(rnd16(longint'(r_in) * (65536 - w) + ((sr + 2) >>> 2) * w)));
    return res;
  endfunction

  task automatic report(string what, logic [23:0] exp_v, logic [23:0] got_v);
    $display("mismatch on %s: expected %h, got %h", what, exp_v, got_v);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_pairs.size() == 0) begin
        $display("result with no request outstanding: %h", m_axis_tdata);
        errors++;
      end else begin
        pair_t e;
        e = expected_pairs.pop_front();
        if (m_axis_tdata[23:0] !== e.left) report("left_out", e.left, m_axis_tdata[23:0]);
        if (m_axis_tdata[47:24] !== e.right) report("right_out", e.right, m_axis_tdata[47:24]);
        pairs_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, 11);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_pair(logic signed [23:0] l_in, logic signed [23:0] r_in);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r_in, l_in};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_pairs.push_back(reverb_predict(l_in, r_in));
    pairs_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_pairs.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    case (idx)
      REG_DELAY0, REG_DELAY1, REG_DELAY2, REG_DELAY3: delay_set[idx] = value & 13'h1FFF;
      REG_FEEDBACK: feedback_set = value & 16'hFFFF;
      REG_DAMPING:  damping_set = value & 16'hFFFF;
      REG_PREDELAY: predelay_set = value & 13'h1FFF;
      REG_WET:      wet_set = value & 17'h1FFFF;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(int unsigned d0, int unsigned d1, int unsigned d2, int unsigned d3,
                           int unsigned fb, int unsigned dm, int unsigned pd, int unsigned wg);
    write_reg(REG_DELAY0, d0);
    write_reg(REG_DELAY1, d1);
    write_reg(REG_DELAY2, d2);
    write_reg(REG_DELAY3, d3);
    write_reg(REG_FEEDBACK, fb);
    write_reg(REG_DAMPING, dm);
    write_reg(REG_PREDELAY, pd);
    write_reg(REG_WET, wg);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 15)) - 24'd8;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic int unsigned rand_delay();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 8191);
    return $urandom_range(0, 40);
  endfunction

  task automatic test_reset_settings();
    send_pair(24'h7FFFFF, 24'h7FFFFF);
    send_pair(24'h800000, 24'h800000);
    send_pair(24'h000000, 24'hFFFFFF);
    send_pair(24'h555555, 24'hAAAAAA);
    send_pair(24'h7FFFFF, 24'h800000);
    wait_idle();
  endtask

  task automatic test_extreme_settings();
    // Silenced left line, shortest loops, longest delay clamped, full feedback.
    write_all(0, 1, 8191, 2, 65535, 0, 0, UNITY_GAIN);
    repeat (6) send_pair(24'h7FFFFF, 24'h800000);
    wait_idle();
    // Damping above one half, wet gain above unity, one-sample predelay.
    write_all(3, 0, 1, 8191, 65535, 65535, 1, 131071);
    repeat (4) send_pair(24'h800000, 24'h7FFFFF);
    wait_idle();
    // Longest predelay, dry only, damping at one half, no feedback.
    write_all(8191, 8191, 0, 0, 0, 32768, 8191, 0);
    repeat (3) send_pair(24'h7FFFFF, 24'h000001);
    wait_idle();
  endtask

  task automatic test_random_phases(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      idle_on = (p % 4 != 3);
      write_all(rand_delay(), rand_delay(), rand_delay(), rand_delay(),
                ($urandom_range(0, 1) != 0) ? $urandom_range(40000, 65535)
                                            : $urandom_range(0, 65535),
                $urandom_range(0, 65535),
                ($urandom_range(0, 1) != 0) ? 0 : rand_delay(),
                ($urandom_range(0, 3) == 0) ? $urandom_range(65536, 131071)
                                            : $urandom_range(0, 65536));
      repeat (per_phase) send_pair(rand_sample(), rand_sample());
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    write_all(5, 9, 2, 13, 60000, 20000, 3, 40000);
    hold_left = 300;
    repeat (12) send_pair(rand_sample(), rand_sample());
    wait_idle();
    repeat (20) send_pair(rand_sample(), rand_sample());
    wait_idle();
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    write_all(7, 1, 4, 11, 65535, 8000, 0, 50000);
    repeat (60) send_pair(rand_sample(), rand_sample());
    wait_idle();
  endtask

  initial begin
    delay_set[0] = DELAY0_RST;
    delay_set[1] = DELAY1_RST;
    delay_set[2] = DELAY2_RST;
    delay_set[3] = DELAY3_RST;
    feedback_set = FEEDBACK_RST;
    damping_set = DAMPING_RST;
    predelay_set = PREDELAY_RST;
    wet_set = WET_RST;
    comb_wp = 0;
    pre_wp = 0;
    foreach (comb_left[i]) begin
      comb_left[i] = 0;
      comb_right[i] = 0;
    end
    foreach (pre_left[i]) begin
      pre_left[i] = 0;
      pre_right[i] = 0;
    end
    foreach (damper_l[i]) begin
      damper_l[i] = 0;
      damper_r[i] = 0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_settings();
    test_extreme_settings();
    test_random_phases(11, 95);
    test_backpressure();
    test_steady_stream();
    $display("Sent %0d stereo requests and checked %0d results over directed extremes,",
             pairs_sent, pairs_checked);
    $display("random settings with and without predelay, stalls and a long output hold-off.");
    if (errors == 0 && expected_pairs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/scpr_pkg.sv
hw/rtl/scpr_ctrl.sv
hw/rtl/scpr_datapath.sv
hw/rtl/stereo_comb_plate_reverb.sv
test/testbench.sv
